@@ sv/tea_pkg.sv @@
// Shared constants, codes and control/status types for the edge adjacency block.
package tea_pkg;

  localparam int MAX_FACES   = 1024;
  localparam int VERTEX_BITS = 24;
  localparam int CORNERS     = 3;
  localparam int FACE_W      = $clog2(MAX_FACES);
  localparam int COUNT_W     = $clog2(MAX_FACES + 1);
  localparam int ENTRY_W     = CORNERS * VERTEX_BITS;
  localparam int EDGE_W      = 2 * VERTEX_BITS;

  // Request kinds
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  typedef logic [VERTEX_BITS-1:0] vertex_t;
  typedef logic [FACE_W-1:0]      face_idx_t;
  typedef logic [COUNT_W-1:0]     count_t;
  typedef logic [EDGE_W-1:0]      edge_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clear;     // empty the store
    logic load;      // append a face
    logic q_latch;   // latch query index and range check
    logic rd_q;      // read the queried face
    logic cap_q;     // capture queried face edges
    logic scan_rd;   // read next face of the scan
    logic out_load;  // move result into output register
  } tea_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic q_bad;     // incoming query index at or beyond face count
    logic scan_last; // current scan read is the last loaded face
    logic out_full;  // output register holds a result not taken this cycle
  } tea_stat_t;

  // Edge with endpoints ordered low then high
  function automatic edge_t edge_norm(input vertex_t p, input vertex_t q);
    edge_t e;
    if (p > q) e = {q, p};
    else       e = {p, q};
    return e;
  endfunction

endpackage

@@ sv/tea_ctrl.sv @@
// Controller state machine sequencing clear, load and query scans.
module tea_ctrl import tea_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic [1:0] in_kind,
  output logic      in_ready,
  input  tea_stat_t stat,
  output tea_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_QRD   = 3'd1;
  localparam logic [2:0] S_QCAP  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_CLEAR) begin
            cmd.clear = 1'b1;
          end else if (in_kind == KIND_LOAD) begin
            cmd.load = 1'b1;
          end else if (in_kind == KIND_QUERY) begin
            cmd.q_latch = 1'b1;
            state_nxt   = stat.q_bad ? S_DONE : S_QRD;
          end
        end
      end
      S_QRD: begin
        cmd.rd_q  = 1'b1;
        state_nxt = S_QCAP;
      end
      S_QCAP: begin
        cmd.cap_q = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

@@ sv/tea_dp.sv @@
// Datapath: face memory, face count, scan counter, edge compare and result register.
module tea_dp import tea_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  tea_cmd_t     cmd,
  output tea_stat_t    stat,
  input  vertex_t      in_vertex_a,
  input  vertex_t      in_vertex_b,
  input  vertex_t      in_vertex_c,
  input  face_idx_t    in_face_index,
  output logic         out_valid,
  input  logic         out_stall,
  output face_idx_t    out_adjacent_0,
  output face_idx_t    out_adjacent_1,
  output face_idx_t    out_adjacent_2,
  output logic         out_found_0,
  output logic         out_found_1,
  output logic         out_found_2,
  output logic         out_bad_index
);

  logic [ENTRY_W-1:0] mem [MAX_FACES];
  logic [ENTRY_W-1:0] rdata_r;
  face_idx_t          rd_addr;

  count_t    count_r;
  face_idx_t q_r;
  logic      bad_r;
  face_idx_t scan_r;
  logic      rd_vld_r;
  face_idx_t rd_idx_r;
  edge_t     qe_r [CORNERS];
  face_idx_t adj_r [CORNERS];
  logic [CORNERS-1:0] fnd_r;
  logic      out_valid_r;

  vertex_t   qv [CORNERS];
  vertex_t   cv [CORNERS];
  edge_t     ce [CORNERS];
  logic [CORNERS-1:0] hit;
  face_idx_t last_idx;

  // Status
  assign last_idx       = face_idx_t'(count_r - count_t'(1));
  assign stat.q_bad     = ({1'b0, in_face_index} >= count_r);
  assign stat.scan_last = (scan_r == last_idx);
  assign stat.out_full  = out_valid_r && out_stall;

  // Face memory: one write port, one registered read port
  assign rd_addr = cmd.rd_q ? q_r : scan_r;
  always_ff @(posedge clk) begin
    if (cmd.load && (count_r < count_t'(MAX_FACES))) begin
      mem[face_idx_t'(count_r)] <= {in_vertex_c, in_vertex_b, in_vertex_a};
    end
    rdata_r <= mem[rd_addr];
  end

  // Face count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
    end else if (cmd.load && (count_r < count_t'(MAX_FACES))) begin
      count_r <= count_r + count_t'(1);
    end
  end

  // Corners of the read entry, and normalized edges of the candidate face
  always_comb begin
    for (int i = 0; i < CORNERS; i++) begin
      cv[i] = rdata_r[i*VERTEX_BITS +: VERTEX_BITS];
      qv[i] = cv[i];
    end
    for (int e = 0; e < CORNERS; e++) begin
      ce[e] = edge_norm(cv[e], cv[(e + 1) % CORNERS]);
    end
  end

  // Match each query edge against every edge of the candidate face
  always_comb begin
    for (int e = 0; e < CORNERS; e++) begin
      hit[e] = 1'b0;
      for (int t = 0; t < CORNERS; t++) begin
        if (qe_r[e] == ce[t]) hit[e] = 1'b1;
      end
    end
  end

  // Query latch, scan counter and read tag
  always_ff @(posedge clk) begin
    if (cmd.q_latch) begin
      q_r   <= in_face_index;
      bad_r <= stat.q_bad;
    end
    if (cmd.cap_q) begin
      scan_r <= '0;
      for (int e = 0; e < CORNERS; e++) begin
        qe_r[e] <= edge_norm(qv[e], qv[(e + 1) % CORNERS]);
      end
    end else if (cmd.scan_rd) begin
      scan_r <= scan_r + face_idx_t'(1);
    end
    rd_idx_r <= scan_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_vld_r <= 1'b0;
    else        rd_vld_r <= cmd.scan_rd;
  end

  // Adjacency accumulation: later matches overwrite earlier ones
  always_ff @(posedge clk) begin
    if (cmd.q_latch) begin
      fnd_r <= '0;
      for (int e = 0; e < CORNERS; e++) adj_r[e] <= '0;
    end else if (rd_vld_r && (rd_idx_r != q_r)) begin
      for (int e = 0; e < CORNERS; e++) begin
        if (hit[e]) begin
          adj_r[e] <= rd_idx_r;
          fnd_r[e] <= 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_adjacent_0 <= adj_r[0];
      out_adjacent_1 <= adj_r[1];
      out_adjacent_2 <= adj_r[2];
      out_found_0    <= fnd_r[0];
      out_found_1    <= fnd_r[1];
      out_found_2    <= fnd_r[2];
      out_bad_index  <= bad_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ sv/triangle_edge_adjacency.sv @@
// Top level of the triangle edge adjacency store.
//
// Input channel (in_valid/in_stall): one request per accepted beat. in_kind
// selects clear (empties the store), load (appends in_vertex_a/b/c at the
// next free slot; ignored once MAX_FACES faces are held) or query (looks up
// the faces sharing each edge of face in_face_index). Other kinds are dropped.
// Clear and load produce no result and leave the block ready for the next request.
// A query produces one result on the output channel (out_valid/out_stall):
// neighbor index and found flag per edge, highest matching index winning,
// or out_bad_index when the face is not loaded. A valid query reads the
// queried face, then scans every loaded face through the single read port of
// the face memory, one per cycle, then passes the drain and done states; the
// result is loaded into the output register from the done state, and the next
// request is taken after that. A bad index query goes straight to done.
// Reset clears the face count and the controller; memory contents are not
// cleared. While the receiver stalls, the result holds in the output register
// and a finished query waits for it before accepting further requests.
module triangle_edge_adjacency import tea_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic [1:0] in_kind,
  input  vertex_t   in_vertex_a,
  input  vertex_t   in_vertex_b,
  input  vertex_t   in_vertex_c,
  input  face_idx_t in_face_index,
  output logic      out_valid,
  input  logic      out_stall,
  output face_idx_t out_adjacent_0,
  output face_idx_t out_adjacent_1,
  output face_idx_t out_adjacent_2,
  output logic      out_found_0,
  output logic      out_found_1,
  output logic      out_found_2,
  output logic      out_bad_index
);

  tea_cmd_t  cmd;
  tea_stat_t stat;
  logic      in_ready;

  assign in_stall = !in_ready;

  // Sequencer
  tea_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and compare
  tea_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_vertex_a    (in_vertex_a),
    .in_vertex_b    (in_vertex_b),
    .in_vertex_c    (in_vertex_c),
    .in_face_index  (in_face_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_adjacent_0 (out_adjacent_0),
    .out_adjacent_1 (out_adjacent_1),
    .out_adjacent_2 (out_adjacent_2),
    .out_found_0    (out_found_0),
    .out_found_1    (out_found_1),
    .out_found_2    (out_found_2),
    .out_bad_index  (out_bad_index)
  );

endmodule

@@ tb/tb_triangle_edge_adjacency.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the triangle edge adjacency store.
module tb_triangle_edge_adjacency;
  import tea_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int NUM_DIR = 24;

  // One result of a query
  typedef struct packed {
    face_idx_t [CORNERS-1:0] adj;
    logic [CORNERS-1:0]      found;
    logic                    bad;
  } adj_result_t;

  typedef struct packed {
    logic [1:0] kind;
    vertex_t    va;
    vertex_t    vb;
    vertex_t    vc;
    face_idx_t  idx;
  } face_req_t;

  // Directed row: request plus an optional hand-written result
  typedef struct packed {
    logic [1:0]  kind;
    vertex_t     va;
    vertex_t     vb;
    vertex_t     vc;
    face_idx_t   idx;
    logic        typed;
    adj_result_t res;
  } dir_row_t;

  localparam adj_result_t RES_BAD   = '{adj: '0, found: '0, bad: 1'b1};
  localparam adj_result_t NO_RESULT = '0;

  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    // start from an empty store
    '{KIND_CLEAR,  24'h000000, 24'h000000, 24'h000000, 10'd0,    1'b0, NO_RESULT},
    // query on the empty store
    '{KIND_QUERY,  24'h000000, 24'h000000, 24'h000000, 10'd0,    1'b1, RES_BAD},
    '{KIND_UNUSED, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 10'd1023, 1'b0, NO_RESULT},
    '{KIND_LOAD,   24'h000000, 24'h000001, 24'h000002, 10'd0,    1'b0, NO_RESULT},
    // shares edge 1-2 with face 0, endpoints reversed
    '{KIND_LOAD,   24'h000002, 24'h000001, 24'h000003, 10'd0,    1'b0, NO_RESULT},
    '{KIND_LOAD,   24'hFFFFFF, 24'h000000, 24'h000002, 10'd0,    1'b0, NO_RESULT},
    // degenerate face and a face sharing its collapsed edge
    '{KIND_LOAD,   24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 10'd0,    1'b0, NO_RESULT},
    '{KIND_LOAD,   24'hFFFFFF, 24'hFFFFFF, 24'h000005, 10'd0,    1'b0, NO_RESULT},
    // two faces on edge 0-1: the later one must win
    '{KIND_LOAD,   24'h000001, 24'h000000, 24'h000007, 10'd0,    1'b0, NO_RESULT},
    '{KIND_LOAD,   24'h000000, 24'h000001, 24'h000009, 10'd0,    1'b0, NO_RESULT},
    '{KIND_QUERY,  24'h000000, 24'h000000, 24'h000000, 10'd0,    1'b0, NO_RESULT},
    '{KIND_QUERY,  24'h000000, 24'h000000, 24'h000000, 10'd3,    1'b0, NO_RESULT},
    '{KIND_QUERY,  24'h000000, 24'h000000, 24'h000000, 10'd6,    1'b0, NO_RESULT},
    '{KIND_QUERY,  24'h000000, 24'h000000, 24'h000000, 10'd4,    1'b0, NO_RESULT},
    // index equal to the count, then the top index
    '{KIND_QUERY,  24'h000000, 24'h000000, 24'h000000, 10'd7,    1'b1, RES_BAD},
    '{KIND_QUERY,  24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 10'd1023, 1'b1, RES_BAD},
    '{KIND_UNUSED, 24'h000000, 24'h000000, 24'h000000, 10'd0,    1'b0, NO_RESULT},
    '{KIND_CLEAR,  24'h000000, 24'h000000, 24'h000000, 10'd0,    1'b0, NO_RESULT},
    '{KIND_QUERY,  24'h000000, 24'h000000, 24'h000000, 10'd0,    1'b1, RES_BAD},
    '{KIND_LOAD,   24'hABCDEF, 24'h123456, 24'h654321, 10'd0,    1'b0, NO_RESULT},
    '{KIND_LOAD,   24'h123456, 24'hABCDEF, 24'h000000, 10'd0,    1'b0, NO_RESULT},
    '{KIND_QUERY,  24'h000000, 24'h000000, 24'h000000, 10'd0,    1'b0, NO_RESULT},
    '{KIND_QUERY,  24'h000000, 24'h000000, 24'h000000, 10'd1,    1'b0, NO_RESULT},
    '{KIND_QUERY,  24'h000000, 24'h000000, 24'h000000, 10'd2,    1'b1, RES_BAD}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  logic [1:0] in_kind = KIND_CLEAR;
  vertex_t   in_vertex_a = '0;
  vertex_t   in_vertex_b = '0;
  vertex_t   in_vertex_c = '0;
  face_idx_t in_face_index = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  face_idx_t out_adjacent_0;
  face_idx_t out_adjacent_1;
  face_idx_t out_adjacent_2;
  logic      out_found_0;
  logic      out_found_1;
  logic      out_found_2;
  logic      out_bad_index;

  // Shadow copy of the face store
  vertex_t     shadow_faces [MAX_FACES][CORNERS];
  int unsigned shadow_count = 0;

  adj_result_t pending_results [$];
  int          errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  triangle_edge_adjacency uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_vertex_a    (in_vertex_a),
    .in_vertex_b    (in_vertex_b),
    .in_vertex_c    (in_vertex_c),
    .in_face_index  (in_face_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_adjacent_0 (out_adjacent_0),
    .out_adjacent_1 (out_adjacent_1),
    .out_adjacent_2 (out_adjacent_2),
    .out_found_0    (out_found_0),
    .out_found_1    (out_found_1),
    .out_found_2    (out_found_2),
    .out_bad_index  (out_bad_index)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // Receiver backpressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Neighbor lookup over the shadow store; later faces overwrite earlier hits
  function automatic adj_result_t predict_neighbors(face_idx_t q);
    adj_result_t res;
    vertex_t     a0, a1, b0, b1;
    res = '0;
    if (int'(q) >= shadow_count) begin
      res.bad = 1'b1;
      return res;
    end
    for (int t = 0; t < shadow_count; t++) begin
      if (t == int'(q)) continue;
      for (int e = 0; e < CORNERS; e++) begin
        a0 = shadow_faces[q][e];
        a1 = shadow_faces[q][(e + 1) % CORNERS];
        for (int te = 0; te < CORNERS; te++) begin
          b0 = shadow_faces[t][te];
          b1 = shadow_faces[t][(te + 1) % CORNERS];
          if ((a0 == b0 && a1 == b1) || (a0 == b1 && a1 == b0)) begin
            res.adj[e]   = face_idx_t'(t);
            res.found[e] = 1'b1;
          end
        end
      end
    end
    return res;
  endfunction

  // Apply an accepted request to the shadow store
  function automatic void absorb_request(face_req_t r, logic typed, adj_result_t typed_res);
    adj_result_t want;
    unique case (r.kind)
      KIND_CLEAR: shadow_count = 0;
      KIND_LOAD: begin
        if (shadow_count < MAX_FACES) begin
          shadow_faces[shadow_count][0] = r.va;
          shadow_faces[shadow_count][1] = r.vb;
          shadow_faces[shadow_count][2] = r.vc;
          shadow_count++;
        end
      end
      KIND_QUERY: begin
        want            = typed ? typed_res : predict_neighbors(r.idx);
        pending_results = {pending_results, want};
      end
      default: ;
    endcase
  endfunction

  // Mostly a small pool so edges collide; sometimes the top or any value
  function automatic vertex_t pick_vertex();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 7) return vertex_t'($urandom_range(11));
    if (sel == 7) return vertex_t'(24'hFFFFFF - $urandom_range(3));
    return vertex_t'($urandom);
  endfunction

  // Drive one request and hold it until accepted; valid is left high
  task automatic send_req(input face_req_t r, input logic typed, input adj_result_t typed_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= r.kind;
    in_vertex_a   <= r.va;
    in_vertex_b   <= r.vb;
    in_vertex_c   <= r.vc;
    in_face_index <= r.idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_request(r, typed, typed_res);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    face_req_t r;
    for (int i = 0; i < NUM_DIR; i++) begin
      r = '{DIR_ROWS[i].kind, DIR_ROWS[i].va, DIR_ROWS[i].vb, DIR_ROWS[i].vc,
            DIR_ROWS[i].idx};
      send_req(r, DIR_ROWS[i].typed, DIR_ROWS[i].res);
    end
  endtask

  // Fill every slot, try one load past capacity, then query the full store
  task automatic run_full_store();
    face_req_t r, first;
    r = '{KIND_CLEAR, 24'h0, 24'h0, 24'h0, 10'd0};
    send_req(r, 1'b0, NO_RESULT);
    for (int i = 0; i < MAX_FACES - 1; i++) begin
      r = '{KIND_LOAD, pick_vertex(), pick_vertex(), pick_vertex(), face_idx_t'($urandom)};
      if (i == 0) first = r;
      send_req(r, 1'b0, NO_RESULT);
    end
    // last slot repeats face 0 rotated, so face 0 sees index 1023 on every edge
    r = '{KIND_LOAD, first.vb, first.vc, first.va, 10'd0};
    send_req(r, 1'b0, NO_RESULT);
    r = '{KIND_LOAD, 24'h800000, 24'h7FFFFF, first.va, 10'd0};
    send_req(r, 1'b0, NO_RESULT);
    r = '{KIND_QUERY, 24'h0, 24'h0, 24'h0, 10'd1023};
    send_req(r, 1'b0, NO_RESULT);
    r.idx = 10'd0;
    send_req(r, 1'b0, NO_RESULT);
    r.idx = face_idx_t'($urandom);
    send_req(r, 1'b0, NO_RESULT);
  endtask

  // Bursts of loads between clears with queries mixed in, plus some noise
  task automatic run_random(input int unsigned n_wanted);
    face_req_t   r;
    int unsigned n_sent;
    int unsigned roll;
    n_sent = 0;
    while (n_sent < n_wanted) begin
      roll = $urandom_range(99);
      r.va  = pick_vertex();
      r.vb  = pick_vertex();
      r.vc  = pick_vertex();
      r.idx = face_idx_t'($urandom);
      if (roll < 4) r.kind = KIND_UNUSED;
      else if (roll < 9 || (shadow_count >= 48 && roll < 30)) r.kind = KIND_CLEAR;
      else if (roll < 55) r.kind = KIND_LOAD;
      else begin
        r.kind = KIND_QUERY;
        if (shadow_count != 0 && $urandom_range(99) < 85)
          r.idx = face_idx_t'($urandom_range(shadow_count - 1));
      end
      send_req(r, 1'b0, NO_RESULT);
      if (r.kind != KIND_UNUSED) n_sent++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin : check_results
    adj_result_t got;
    adj_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.adj[0]   = out_adjacent_0;
      got.adj[1]   = out_adjacent_1;
      got.adj[2]   = out_adjacent_2;
      got.found[0] = out_found_0;
      got.found[1] = out_found_1;
      got.found[2] = out_found_2;
      got.bad      = out_bad_index;
      if (pending_results.size() == 0) begin
        $error("result with no query outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        for (int e = 0; e < CORNERS; e++) begin
          if (got.adj[e] !== want.adj[e]) begin
            $error("adjacent_%0d: expected %0d, got %0d", e, want.adj[e], got.adj[e]);
            errors++;
          end
          if (got.found[e] !== want.found[e]) begin
            $error("found_%0d: expected %0d, got %0d", e, want.found[e], got.found[e]);
            errors++;
          end
        end
        if (got.bad !== want.bad) begin
          $error("bad_index: expected %0d, got %0d", want.bad, got.bad);
          errors++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no idling on either side
    run_directed();
    run_full_store();
    drain_results();
    run_random(145);
    drain_results();

    // sender idles
    send_idle_pct = 48;
    run_random(145);
    drain_results();

    // receiver stalls
    send_idle_pct = 0;
    stall_pct     = 48;
    run_random(145);
    drain_results();

    // both sides idle
    send_idle_pct = 27;
    stall_pct     = 27;
    run_directed();
    run_random(145);
    drain_results();

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
